// File: src/vdsc_pkg.sv
package vdsc_pkg;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned TIMER_W    = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BRAKE_CONFLICT_MIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_CONFLICT_MAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PEDAL_MISMATCH_LIMIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PEDAL_MISMATCH_TIME   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HV_MIN_VOLTAGE        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BRAKE_START_THRESHOLD = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BUZZER_TIME           = 3'd6;

  typedef enum logic [2:0] {
    MODE_INIT  = 3'd0,
    MODE_LV    = 3'd1,
    MODE_TS    = 3'd2,
    MODE_RTD   = 3'd3,
    MODE_DRIVE = 3'd4,
    MODE_FAULT = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    FK_NONE  = 3'd0,
    FK_LOOP  = 3'd1,
    FK_BRAKE = 3'd2,
    FK_PEDAL = 3'd3,
    FK_EXT   = 3'd4
  } fault_t;

  typedef struct packed {
    logic [11:0] brake_conflict_min;
    logic [6:0]  throttle_conflict_max;
    logic [6:0]  pedal_mismatch_limit;
    logic [15:0] pedal_mismatch_time_ms;
    logic [9:0]  hv_min_voltage;
    logic [11:0] brake_start_threshold;
    logic [15:0] buzzer_time_ms;
  } cfg_t;

  typedef struct packed {
    logic [9:0]  delta_ms;
    logic [3:0]  external_fault;
    logic        loop_closed;
    logic [11:0] brake_level;
    logic [6:0]  throttle_level;
    logic [6:0]  pedal_sensor_a;
    logic [6:0]  pedal_sensor_b;
    logic [9:0]  hv_voltage;
    logic        start_pressed;
    logic        clear_pressed;
  } item_t;

  typedef struct packed {
    mode_t              mode;
    fault_t             fault_kind;
    logic [3:0]         fault_code;
    logic               enable;
    logic               buzzer;
    logic [TIMER_W-1:0] buzzer_timer;
    logic               buzzer_timing;
    logic [TIMER_W-1:0] mismatch_timer;
  } state_t;

  typedef struct packed {
    mode_t      mode;
    fault_t     fault_kind;
    logic [3:0] fault_ext_code;
    logic       drive_enable;
    logic       buzzer_on;
  } result_t;

  // Add elapsed time to a timer, stopping at the timer's top value
  function automatic logic [TIMER_W-1:0] sat_add(input logic [TIMER_W-1:0] a,
                                                 input logic [9:0] b);
    logic [TIMER_W:0] s;
    s = {1'b0, a} + (TIMER_W+1)'(b);
    return s[TIMER_W] ? {TIMER_W{1'b1}} : s[TIMER_W-1:0];
  endfunction

endpackage

// File: src/vdsc_if.sv
interface vdsc_tick_if;
  logic        valid;
  logic        ready;
  logic [9:0]  delta_ms;
  logic [3:0]  external_fault;
  logic        loop_closed;
  logic [11:0] brake_level;
  logic [6:0]  throttle_level;
  logic [6:0]  pedal_sensor_a;
  logic [6:0]  pedal_sensor_b;
  logic [9:0]  hv_voltage;
  logic        start_pressed;
  logic        clear_pressed;

  modport source (output valid, delta_ms, external_fault, loop_closed, brake_level,
                  throttle_level, pedal_sensor_a, pedal_sensor_b, hv_voltage,
                  start_pressed, clear_pressed, input ready);
  modport sink (input valid, delta_ms, external_fault, loop_closed, brake_level,
                throttle_level, pedal_sensor_a, pedal_sensor_b, hv_voltage,
                start_pressed, clear_pressed, output ready);
endinterface

interface vdsc_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [2:0] fault_kind;
  logic [3:0] fault_ext_code;
  logic       drive_enable;
  logic       buzzer_on;

  modport source (output valid, mode, fault_kind, fault_ext_code, drive_enable, buzzer_on,
                  input ready);
  modport sink (input valid, mode, fault_kind, fault_ext_code, drive_enable, buzzer_on,
                output ready);
endinterface

// File: src/vdsc_cfg.sv
module vdsc_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [vdsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vdsc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output vdsc_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.brake_conflict_min     <= 12'd30;
      cfg.throttle_conflict_max  <= 7'd25;
      cfg.pedal_mismatch_limit   <= 7'd10;
      cfg.pedal_mismatch_time_ms <= 16'd100;
      cfg.hv_min_voltage         <= 10'd60;
      cfg.brake_start_threshold  <= 12'd15;
      cfg.buzzer_time_ms         <= 16'd2000;
    end else if (cfg_we) begin
      case (cfg_index)
        vdsc_pkg::REG_BRAKE_CONFLICT_MIN:    cfg.brake_conflict_min     <= cfg_data[11:0];
        vdsc_pkg::REG_THROTTLE_CONFLICT_MAX: cfg.throttle_conflict_max  <= cfg_data[6:0];
        vdsc_pkg::REG_PEDAL_MISMATCH_LIMIT:  cfg.pedal_mismatch_limit   <= cfg_data[6:0];
        vdsc_pkg::REG_PEDAL_MISMATCH_TIME:   cfg.pedal_mismatch_time_ms <= cfg_data[15:0];
        vdsc_pkg::REG_HV_MIN_VOLTAGE:        cfg.hv_min_voltage         <= cfg_data[9:0];
        vdsc_pkg::REG_BRAKE_START_THRESHOLD: cfg.brake_start_threshold  <= cfg_data[11:0];
        vdsc_pkg::REG_BUZZER_TIME:           cfg.buzzer_time_ms         <= cfg_data[15:0];
        default: begin
          // drop writes past the last register
        end
      endcase
    end
  end

endmodule

// File: src/vdsc_step.sv
module vdsc_step (
  input  vdsc_pkg::state_t  st,
  input  vdsc_pkg::item_t   it,
  input  vdsc_pkg::cfg_t    cfg,
  output vdsc_pkg::state_t  nx,
  output vdsc_pkg::result_t res
);

  vdsc_pkg::fault_t kind;
  logic [3:0]       code;
  logic [6:0]       diff;
  logic [15:0]      mt_sat;

  assign diff = (it.pedal_sensor_a > it.pedal_sensor_b) ?
                (it.pedal_sensor_a - it.pedal_sensor_b) :
                (it.pedal_sensor_b - it.pedal_sensor_a);
  assign mt_sat = vdsc_pkg::sat_add(st.mismatch_timer, it.delta_ms);

  always_comb begin
    nx   = st;
    kind = vdsc_pkg::FK_NONE;
    code = 4'd0;

    // Fault checks in priority order
    if (it.external_fault != 4'd0) begin
      kind = vdsc_pkg::FK_EXT;
      code = it.external_fault;
    end else if (!it.loop_closed) begin
      kind = vdsc_pkg::FK_LOOP;
    end else if (it.brake_level > cfg.brake_conflict_min &&
                 it.throttle_level > cfg.throttle_conflict_max) begin
      kind = vdsc_pkg::FK_BRAKE;
    end else if (diff > cfg.pedal_mismatch_limit) begin
      nx.mismatch_timer = mt_sat;
      if (mt_sat >= cfg.pedal_mismatch_time_ms) kind = vdsc_pkg::FK_PEDAL;
    end else begin
      nx.mismatch_timer = '0;
    end

    if (kind != vdsc_pkg::FK_NONE) begin
      nx.mode       = vdsc_pkg::MODE_FAULT;
      nx.fault_kind = kind;
      nx.fault_code = code;
    end

    if (st.buzzer_timing) nx.buzzer_timer = vdsc_pkg::sat_add(st.buzzer_timer, it.delta_ms);

    case (nx.mode)
      vdsc_pkg::MODE_LV: begin
        nx.enable = 1'b0;
        if (it.hv_voltage > cfg.hv_min_voltage) nx.mode = vdsc_pkg::MODE_TS;
      end
      vdsc_pkg::MODE_TS: begin
        nx.enable = 1'b0;
        if (it.hv_voltage < cfg.hv_min_voltage) begin
          nx.mode = vdsc_pkg::MODE_LV;
        end else if (it.brake_level > cfg.brake_start_threshold && it.start_pressed) begin
          nx.mode          = vdsc_pkg::MODE_RTD;
          nx.buzzer_timer  = '0;
          nx.buzzer_timing = 1'b1;
          nx.buzzer        = 1'b1;
        end
      end
      vdsc_pkg::MODE_RTD: begin
        if (nx.buzzer_timer >= cfg.buzzer_time_ms) begin
          nx.buzzer        = 1'b0;
          nx.buzzer_timing = 1'b0;
          nx.mode          = vdsc_pkg::MODE_DRIVE;
        end
      end
      vdsc_pkg::MODE_DRIVE: begin
        nx.enable = 1'b1;
        if (it.start_pressed) nx.mode = vdsc_pkg::MODE_TS;
      end
      vdsc_pkg::MODE_FAULT: begin
        nx.enable        = 1'b0;
        nx.buzzer        = 1'b0;
        nx.buzzer_timing = 1'b0;
        // recheck with no added time gives the same verdict as the first pass
        if (kind == vdsc_pkg::FK_NONE && it.clear_pressed) begin
          nx.fault_kind = vdsc_pkg::FK_NONE;
          nx.fault_code = 4'd0;
          nx.mode       = vdsc_pkg::MODE_LV;
        end
      end
      default: nx.mode = vdsc_pkg::MODE_LV;
    endcase

    res.mode           = nx.mode;
    res.fault_kind     = nx.fault_kind;
    res.fault_ext_code = (nx.fault_kind == vdsc_pkg::FK_EXT) ? nx.fault_code : 4'd0;
    res.drive_enable   = nx.enable;
    res.buzzer_on      = nx.buzzer;
  end

endmodule

// File: src/vehicle_drive_state_controller.sv
// Channel  | Dir | Contents
// ---------+-----+---------------------------------------------------------
// tick     | in  | one sensor tick: elapsed ms, fault code, loop, pedals, HV, buttons
// result   | out | mode, latched fault kind and code, drive enable, buzzer
// cfg_*    | in  | write-only register port, seven thresholds and times
//
// A request lands in the input register; when the result register is free or being
// drained, its result loads the result register and the controller state advances
// with it. One tick per cycle sustained while the result side is ready.
// rst is synchronous, active high: mode INIT, no fault, timers at zero,
// registers at their defaults.
// A stalled result holds the result register and a full input register; tick.ready drops only when both are full.
module vehicle_drive_state_controller (
  input  logic                            clk,
  input  logic                            rst,
  vdsc_tick_if.sink                       tick,
  vdsc_result_if.source                   result,
  input  logic                            cfg_we,
  input  logic [vdsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vdsc_pkg::CFG_DATA_W-1:0] cfg_data
);

  vdsc_pkg::cfg_t    cfg;
  vdsc_pkg::item_t   tick_q;
  logic              tick_vld;
  vdsc_pkg::state_t  st;
  vdsc_pkg::state_t  st_next;
  vdsc_pkg::result_t res;
  vdsc_pkg::result_t res_next;
  logic              res_vld;
  logic              advance;

  vdsc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  vdsc_step u_step (
    .st  (st),
    .it  (tick_q),
    .cfg (cfg),
    .nx  (st_next),
    .res (res_next)
  );

  // Advance the held tick when the result register is free or being drained
  assign advance    = tick_vld && (!res_vld || result.ready);
  assign tick.ready = !tick_vld || advance;

  // Input register: take a new request whenever the slot is free or moving on
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_vld <= 1'b0;
    end else if (tick.ready) begin
      tick_vld <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      tick_q.delta_ms       <= tick.delta_ms;
      tick_q.external_fault <= tick.external_fault;
      tick_q.loop_closed    <= tick.loop_closed;
      tick_q.brake_level    <= tick.brake_level;
      tick_q.throttle_level <= tick.throttle_level;
      tick_q.pedal_sensor_a <= tick.pedal_sensor_a;
      tick_q.pedal_sensor_b <= tick.pedal_sensor_b;
      tick_q.hv_voltage     <= tick.hv_voltage;
      tick_q.start_pressed  <= tick.start_pressed;
      tick_q.clear_pressed  <= tick.clear_pressed;
    end
  end

  // Controller state: advance once per processed tick
  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode           <= vdsc_pkg::MODE_INIT;
      st.fault_kind     <= vdsc_pkg::FK_NONE;
      st.fault_code     <= 4'd0;
      st.enable         <= 1'b0;
      st.buzzer         <= 1'b0;
      st.buzzer_timer   <= '0;
      st.buzzer_timing  <= 1'b0;
      st.mismatch_timer <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register: load with the state update, clear once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (advance) begin
      res_vld <= 1'b1;
    end else if (result.ready) begin
      res_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) res <= res_next;
  end

  assign result.valid          = res_vld;
  assign result.mode           = res.mode;
  assign result.fault_kind     = res.fault_kind;
  assign result.fault_ext_code = res.fault_ext_code;
  assign result.drive_enable   = res.drive_enable;
  assign result.buzzer_on      = res.buzzer_on;

endmodule

// File: src/vdsc_checker.sv
module vdsc_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [2:0] mode,
  input logic [2:0] fault_kind,
  input logic [3:0] fault_ext_code,
  input logic       drive_enable,
  input logic       buzzer_on
);

  // Inverter enable only in DRIVING or the tick after leaving it
  assert property (@(posedge clk) disable iff (rst)
    res_valid && drive_enable |->
      mode == vdsc_pkg::MODE_DRIVE || mode == vdsc_pkg::MODE_TS)
    else $error("drive enable outside driving");

  assert property (@(posedge clk) disable iff (rst)
    res_valid && buzzer_on |-> mode == vdsc_pkg::MODE_RTD)
    else $error("buzzer outside ready-to-drive");

  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (mode == vdsc_pkg::MODE_FAULT) == (fault_kind != vdsc_pkg::FK_NONE))
    else $error("fault mode and latched fault disagree");

  assert property (@(posedge clk) disable iff (rst)
    res_valid && fault_ext_code != 4'd0 |-> fault_kind == vdsc_pkg::FK_EXT)
    else $error("external code without external fault");

  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(mode) && $stable(fault_kind))
    else $error("stalled result changed");

endmodule

bind vehicle_drive_state_controller vdsc_checker u_vdsc_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (result.valid),
  .res_ready      (result.ready),
  .mode           (result.mode),
  .fault_kind     (result.fault_kind),
  .fault_ext_code (result.fault_ext_code),
  .drive_enable   (result.drive_enable),
  .buzzer_on      (result.buzzer_on)
);

// File: tb/vehicle_drive_state_controller_tb.sv
`timescale 1ns / 100ps

module vehicle_drive_state_controller_tb;

  // Index past the last register; writes there must leave every threshold alone.
  localparam logic [vdsc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int unsigned TIMER_TOP = 65535;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [vdsc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [vdsc_pkg::CFG_DATA_W-1:0] cfg_data;

  vdsc_tick_if tick_ch();
  vdsc_result_if res_ch();

  vehicle_drive_state_controller DUT (
    .clk(clk),
    .rst(rst),
    .tick(tick_ch),
    .result(res_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Shadow of the thresholds and timers the controller should be holding.
  vdsc_pkg::cfg_t limits;

  // Shadow of the controller state, advanced once per accepted request.
  vdsc_pkg::mode_t st_mode = vdsc_pkg::MODE_INIT;
  vdsc_pkg::fault_t st_fault = vdsc_pkg::FK_NONE;
  logic [3:0] st_code = '0;
  logic st_enable = 1'b0;
  logic st_buzzer = 1'b0;
  logic [15:0] buzz_elapsed = '0;
  logic buzz_running = 1'b0;
  logic [15:0] disagree_elapsed = '0;

  vdsc_pkg::item_t backlog[$];          // requests waiting for the driver
  vdsc_pkg::item_t on_bus;              // request currently presented on the tick channel
  vdsc_pkg::result_t expected_results[$];
  vdsc_pkg::result_t want_res;

  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;
  int staged = 0;
  int ticks_sent = 0;
  int results_checked = 0;
  int settings_loaded = 0;
  int drive_entries = 0;
  int fault_hits [5];

  task automatic report_error(input string what);
    error_count++;
    if (error_count <= 40) $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  // Add elapsed milliseconds to a timer, pinning at the top value.
  function automatic logic [15:0] clip_add(input logic [15:0] acc, input logic [9:0] dt);
    int unsigned total;
    total = int'(acc) + int'(dt);
    return (total > TIMER_TOP) ? 16'hFFFF : total[15:0];
  endfunction

  // Run the fault checks in priority order. The sensor disagreement timer
  // advances by dt while the sensors disagree and clears once they agree.
  function automatic vdsc_pkg::fault_t scan_faults(input vdsc_pkg::item_t t,
                                                   input logic [9:0] dt,
                                                   output logic [3:0] ext);
    logic [6:0] spread;
    ext = '0;
    if (t.external_fault != '0) begin
      ext = t.external_fault;
      return vdsc_pkg::FK_EXT;
    end
    if (!t.loop_closed) return vdsc_pkg::FK_LOOP;
    if (t.brake_level > limits.brake_conflict_min &&
        t.throttle_level > limits.throttle_conflict_max) return vdsc_pkg::FK_BRAKE;
    spread = (t.pedal_sensor_a > t.pedal_sensor_b) ? t.pedal_sensor_a - t.pedal_sensor_b
                                                   : t.pedal_sensor_b - t.pedal_sensor_a;
    if (spread > limits.pedal_mismatch_limit) begin
      disagree_elapsed = clip_add(disagree_elapsed, dt);
      if (disagree_elapsed >= limits.pedal_mismatch_time_ms) return vdsc_pkg::FK_PEDAL;
    end else begin
      disagree_elapsed = '0;
    end
    return vdsc_pkg::FK_NONE;
  endfunction

  // Advance the shadow controller by one tick and return what it reports.
  function automatic vdsc_pkg::result_t advance_controller(input vdsc_pkg::item_t t);
    vdsc_pkg::fault_t kind;
    logic [3:0] code;
    logic [3:0] spare;
    vdsc_pkg::result_t r;
    kind = scan_faults(t, t.delta_ms, code);
    if (kind != vdsc_pkg::FK_NONE) begin
      st_mode = vdsc_pkg::MODE_FAULT;
      st_fault = kind;
      st_code = code;
      fault_hits[int'(kind)]++;
    end
    if (buzz_running) buzz_elapsed = clip_add(buzz_elapsed, t.delta_ms);
    case (st_mode)
      vdsc_pkg::MODE_LV: begin
        st_enable = 1'b0;
        if (t.hv_voltage > limits.hv_min_voltage) st_mode = vdsc_pkg::MODE_TS;
      end
      vdsc_pkg::MODE_TS: begin
        st_enable = 1'b0;
        if (t.hv_voltage < limits.hv_min_voltage) begin
          st_mode = vdsc_pkg::MODE_LV;
        end else if (t.brake_level > limits.brake_start_threshold && t.start_pressed) begin
          st_mode = vdsc_pkg::MODE_RTD;
          buzz_elapsed = '0;
          buzz_running = 1'b1;
          st_buzzer = 1'b1;
        end
      end
      vdsc_pkg::MODE_RTD: begin
        if (buzz_elapsed >= limits.buzzer_time_ms) begin
          st_buzzer = 1'b0;
          buzz_running = 1'b0;
          st_mode = vdsc_pkg::MODE_DRIVE;
          drive_entries++;
        end
      end
      vdsc_pkg::MODE_DRIVE: begin
        // enable lags the mode by one tick in both directions
        st_enable = 1'b1;
        if (t.start_pressed) st_mode = vdsc_pkg::MODE_TS;
      end
      vdsc_pkg::MODE_FAULT: begin
        st_enable = 1'b0;
        st_buzzer = 1'b0;
        buzz_running = 1'b0;
        // recheck with no added time; only a clean tick plus the reset button clears
        if (scan_faults(t, 10'd0, spare) == vdsc_pkg::FK_NONE && t.clear_pressed) begin
          st_fault = vdsc_pkg::FK_NONE;
          st_code = '0;
          st_mode = vdsc_pkg::MODE_LV;
        end
      end
      default: st_mode = vdsc_pkg::MODE_LV;
    endcase
    r.mode = st_mode;
    r.fault_kind = st_fault;
    r.fault_ext_code = (st_fault == vdsc_pkg::FK_EXT) ? st_code : 4'd0;
    r.drive_enable = st_enable;
    r.buzzer_on = st_buzzer;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request construction
  // ---------------------------------------------------------------------------

  function automatic vdsc_pkg::item_t tick_of(input int dt, input int ext, input int loop_ok,
                                              input int brake, input int thr, input int sa,
                                              input int sb, input int hv, input int start,
                                              input int clear);
    vdsc_pkg::item_t t;
    t.delta_ms = 10'(dt);
    t.external_fault = 4'(ext);
    t.loop_closed = 1'(loop_ok);
    t.brake_level = 12'(brake);
    t.throttle_level = 7'(thr);
    t.pedal_sensor_a = 7'(sa);
    t.pedal_sensor_b = 7'(sb);
    t.hv_voltage = 10'(hv);
    t.start_pressed = 1'(start);
    t.clear_pressed = 1'(clear);
    return t;
  endfunction

  function automatic logic [9:0] pick_delta();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return 10'($urandom_range(0, 20));
    if (r < 9) return 10'($urandom_range(0, 1000));
    return 10'($urandom_range(1000, 1023));
  endfunction

  function automatic logic [9:0] hv_low();
    if (limits.hv_min_voltage == '0) return '0;
    return 10'($urandom_range(0, int'(limits.hv_min_voltage) - 1));
  endfunction

  function automatic logic [9:0] hv_high();
    if (limits.hv_min_voltage == 10'h3FF) return 10'h3FF;
    return 10'($urandom_range(int'(limits.hv_min_voltage) + 1, 1023));
  endfunction

  // A tick that trips no fault under the current thresholds.
  function automatic vdsc_pkg::item_t calm_tick(input logic [9:0] hv, input logic start,
                                                input logic clear);
    vdsc_pkg::item_t t;
    int a, b, lim;
    t.delta_ms = pick_delta();
    t.external_fault = '0;
    t.loop_closed = 1'b1;
    t.brake_level = $urandom_range(0, 1) ? 12'($urandom_range(0, 100))
                                         : 12'($urandom_range(0, 4095));
    if (t.brake_level > limits.brake_conflict_min)
      t.throttle_level = 7'($urandom_range(0, int'(limits.throttle_conflict_max)));
    else
      t.throttle_level = 7'($urandom_range(0, 100));
    lim = int'(limits.pedal_mismatch_limit);
    a = int'($urandom_range(0, 100));
    b = a + int'($urandom_range(0, 2 * lim)) - lim;
    if (b < 0) b = 0;
    if (b > 127) b = 127;
    t.pedal_sensor_a = 7'(a);
    t.pedal_sensor_b = 7'(b);
    t.hv_voltage = hv;
    t.start_pressed = start;
    t.clear_pressed = clear;
    return t;
  endfunction

  // Anything goes, including readings past their nominal range.
  function automatic vdsc_pkg::item_t rough_tick();
    vdsc_pkg::item_t t;
    t.delta_ms = 10'($urandom);
    t.external_fault = $urandom_range(0, 1) ? 4'd0 : 4'($urandom);
    t.loop_closed = ($urandom_range(0, 4) != 0);
    t.brake_level = 12'($urandom);
    t.throttle_level = 7'($urandom);
    t.pedal_sensor_a = 7'($urandom);
    t.pedal_sensor_b = 7'($urandom);
    t.hv_voltage = 10'($urandom);
    t.start_pressed = 1'($urandom_range(0, 1));
    t.clear_pressed = 1'($urandom_range(0, 1));
    return t;
  endfunction

  function automatic void stage(input vdsc_pkg::item_t t);
    backlog.push_back(t);
    staged++;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present staged requests, hold each until it is taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      tick_ch.valid <= 1'b0;
    end else begin
      if (tick_ch.valid && tick_ch.ready) begin
        expected_results.push_back(advance_controller(on_bus));
        ticks_sent++;
      end
      if (!tick_ch.valid || tick_ch.ready) begin
        if (backlog.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          on_bus = backlog.pop_front();
          tick_ch.delta_ms <= on_bus.delta_ms;
          tick_ch.external_fault <= on_bus.external_fault;
          tick_ch.loop_closed <= on_bus.loop_closed;
          tick_ch.brake_level <= on_bus.brake_level;
          tick_ch.throttle_level <= on_bus.throttle_level;
          tick_ch.pedal_sensor_a <= on_bus.pedal_sensor_a;
          tick_ch.pedal_sensor_b <= on_bus.pedal_sensor_b;
          tick_ch.hv_voltage <= on_bus.hv_voltage;
          tick_ch.start_pressed <= on_bus.start_pressed;
          tick_ch.clear_pressed <= on_bus.clear_pressed;
          tick_ch.valid <= 1'b1;
        end else begin
          tick_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: take results with random back-pressure, check against the
  // oldest outstanding prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_error("result arrived with no request outstanding");
        end else begin
          want_res = expected_results.pop_front();
          if (res_ch.mode !== want_res.mode)
            report_error($sformatf("result %0d: mode %0d, expected %0d",
                                   results_checked, res_ch.mode, want_res.mode));
          if (res_ch.fault_kind !== want_res.fault_kind)
            report_error($sformatf("result %0d: fault_kind %0d, expected %0d",
                                   results_checked, res_ch.fault_kind, want_res.fault_kind));
          if (res_ch.fault_ext_code !== want_res.fault_ext_code)
            report_error($sformatf("result %0d: fault_ext_code %0d, expected %0d",
                                   results_checked, res_ch.fault_ext_code,
                                   want_res.fault_ext_code));
          if (res_ch.drive_enable !== want_res.drive_enable)
            report_error($sformatf("result %0d: drive_enable %b, expected %b",
                                   results_checked, res_ch.drive_enable,
                                   want_res.drive_enable));
          if (res_ch.buzzer_on !== want_res.buzzer_on)
            report_error($sformatf("result %0d: buzzer_on %b, expected %b",
                                   results_checked, res_ch.buzzer_on, want_res.buzzer_on));
          results_checked++;
        end
      end
      res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing helpers
  // ---------------------------------------------------------------------------

  // Hold until every staged request is taken and answered, then let the
  // two-stage pipe go quiet. Ends on a falling edge to stay clear of the driver.
  task automatic settle();
    do begin
      @(negedge clk);
    end while (backlog.size() != 0 || tick_ch.valid || expected_results.size() != 0);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic program_reg(input logic [vdsc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      vdsc_pkg::REG_BRAKE_CONFLICT_MIN:    limits.brake_conflict_min = val[11:0];
      vdsc_pkg::REG_THROTTLE_CONFLICT_MAX: limits.throttle_conflict_max = val[6:0];
      vdsc_pkg::REG_PEDAL_MISMATCH_LIMIT:  limits.pedal_mismatch_limit = val[6:0];
      vdsc_pkg::REG_PEDAL_MISMATCH_TIME:   limits.pedal_mismatch_time_ms = val;
      vdsc_pkg::REG_HV_MIN_VOLTAGE:        limits.hv_min_voltage = val[9:0];
      vdsc_pkg::REG_BRAKE_START_THRESHOLD: limits.brake_start_threshold = val[11:0];
      vdsc_pkg::REG_BUZZER_TIME:           limits.buzzer_time_ms = val;
      default: ;
    endcase
  endtask

  // Write all seven registers back to back, then a stray write to the unused
  // index, which must change nothing.
  task automatic load_limits(input logic [15:0] brake_min, input logic [15:0] thr_max,
                             input logic [15:0] spread_max, input logic [15:0] spread_ms,
                             input logic [15:0] hv_min, input logic [15:0] brake_go,
                             input logic [15:0] buzz_ms);
    program_reg(vdsc_pkg::REG_BRAKE_CONFLICT_MIN, brake_min);
    program_reg(vdsc_pkg::REG_THROTTLE_CONFLICT_MAX, thr_max);
    program_reg(vdsc_pkg::REG_PEDAL_MISMATCH_LIMIT, spread_max);
    program_reg(vdsc_pkg::REG_PEDAL_MISMATCH_TIME, spread_ms);
    program_reg(vdsc_pkg::REG_HV_MIN_VOLTAGE, hv_min);
    program_reg(vdsc_pkg::REG_BRAKE_START_THRESHOLD, brake_go);
    program_reg(vdsc_pkg::REG_BUZZER_TIME, buzz_ms);
    program_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_loaded++;
    @(negedge clk);
  endtask

  // Stage random traffic until the running total reaches goal. Most of it is
  // full drive cycles and fault/recovery episodes so the deep modes get
  // visited; the rest is calm filler and raw noise.
  task automatic stage_until(input int goal);
    vdsc_pkg::item_t t;
    int n, dt, a, b, pick;
    while (staged < goal) begin
      pick = int'($urandom_range(0, 99));
      if (pick < 40) begin
        // LV -> TS -> buzzer -> DRIVING -> TS, clearing any old fault first
        repeat ($urandom_range(1, 2)) stage(calm_tick(hv_low(), 1'b0, 1'b1));
        stage(calm_tick(hv_high(), 1'b0, 1'b0));
        t = calm_tick(hv_high(), 1'b1, 1'b0);
        t.brake_level = (limits.brake_start_threshold < 12'hFFF)
                        ? 12'($urandom_range(int'(limits.brake_start_threshold) + 1, 4095))
                        : 12'hFFF;
        if (t.brake_level > limits.brake_conflict_min)
          t.throttle_level = 7'($urandom_range(0, int'(limits.throttle_conflict_max)));
        stage(t);
        // the longest buzzer times run the timer into saturation
        if (limits.buzzer_time_ms > 16'd5000) begin
          n = int'(limits.buzzer_time_ms) / 1000 + 2;
          dt = 1000;
        end else begin
          n = int'($urandom_range(1, 6));
          dt = int'(limits.buzzer_time_ms) / n + int'($urandom_range(0, 100));
          if (dt > 1000) dt = 1000;
        end
        repeat (n) begin
          t = calm_tick(hv_high(), 1'b0, 1'b0);
          t.delta_ms = 10'(dt);
          stage(t);
        end
        repeat ($urandom_range(1, 5)) stage(calm_tick(hv_high(), 1'b0, 1'b0));
        stage(calm_tick(hv_high(), 1'b1, 1'b0));
        if ($urandom_range(0, 1)) stage(calm_tick(hv_low(), 1'b0, 1'b0));
      end else if (pick < 65) begin
        // trip one fault, wander a little, then try to clear it
        t = calm_tick(10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)), 1'b0);
        case ($urandom_range(0, 3))
          0: begin
            t.external_fault = 4'($urandom_range(1, 15));
            stage(t);
          end
          1: begin
            t.loop_closed = 1'b0;
            stage(t);
          end
          2: begin
            t.brake_level = (limits.brake_conflict_min < 12'hFFF)
                            ? 12'($urandom_range(int'(limits.brake_conflict_min) + 1, 4095))
                            : 12'hFFF;
            t.throttle_level = (limits.throttle_conflict_max < 7'h7F)
                               ? 7'($urandom_range(int'(limits.throttle_conflict_max) + 1,
                                                   127))
                               : 7'h7F;
            stage(t);
          end
          default: begin
            // sensor disagreement held long enough to trip; now and then a
            // very long run that pins the timer at its top
            if ($urandom_range(0, 19) == 0) begin
              n = 70;
              dt = 1000;
            end else begin
              n = int'($urandom_range(1, 5));
              dt = int'(limits.pedal_mismatch_time_ms) / n + int'($urandom_range(0, 40));
              if (dt > 1000) dt = 1000;
            end
            repeat (n) begin
              t = calm_tick(10'($urandom_range(0, 1023)), 1'b0, 1'b0);
              t.delta_ms = 10'(dt);
              if (limits.pedal_mismatch_limit < 7'h7F) begin
                a = int'($urandom_range(int'(limits.pedal_mismatch_limit) + 1, 127));
                b = a - int'($urandom_range(int'(limits.pedal_mismatch_limit) + 1, a));
                if ($urandom_range(0, 1)) begin
                  t.pedal_sensor_a = 7'(a);
                  t.pedal_sensor_b = 7'(b);
                end else begin
                  t.pedal_sensor_a = 7'(b);
                  t.pedal_sensor_b = 7'(a);
                end
              end
              stage(t);
            end
          end
        endcase
        repeat ($urandom_range(0, 3))
          stage($urandom_range(0, 1) ? rough_tick()
                                     : calm_tick(10'($urandom_range(0, 1023)), 1'b0, 1'b1));
        stage(calm_tick(10'($urandom_range(0, 1023)), 1'b0, 1'b1));
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 5))
          stage(calm_tick(10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1))));
      end else begin
        repeat ($urandom_range(1, 4)) stage(rough_tick());
      end
    end
  endtask

  // One random phase; halfway through, the sender holds off until every
  // outstanding request has been answered.
  task automatic run_phase(input int count);
    int first;
    first = staged;
    stage_until(first + count / 2);
    settle();
    stage_until(first + count);
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    tick_ch.valid = 1'b0;
    tick_ch.delta_ms = '0;
    tick_ch.external_fault = '0;
    tick_ch.loop_closed = 1'b0;
    tick_ch.brake_level = '0;
    tick_ch.throttle_level = '0;
    tick_ch.pedal_sensor_a = '0;
    tick_ch.pedal_sensor_b = '0;
    tick_ch.hv_voltage = '0;
    tick_ch.start_pressed = 1'b0;
    tick_ch.clear_pressed = 1'b0;
    res_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    // thresholds as they come out of reset
    limits.brake_conflict_min = 12'd30;
    limits.throttle_conflict_max = 7'd25;
    limits.pedal_mismatch_limit = 7'd10;
    limits.pedal_mismatch_time_ms = 16'd100;
    limits.hv_min_voltage = 10'd60;
    limits.brake_start_threshold = 12'd15;
    limits.buzzer_time_ms = 16'd2000;
    rst = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Sender mostly busy, receiver stalling hard.
    send_gap_pct = 8;
    recv_stall_pct = 78;

    // Directed walk at reset thresholds.
    stage(tick_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));              // all zero: loop open
    stage(tick_of(10, 0, 1, 0, 0, 20, 20, 0, 0, 1));           // clean recheck, clear
    stage(tick_of(1023, 15, 1, 4095, 127, 127, 0, 1023, 1, 1)); // every field but sensor b at top
    stage(tick_of(5, 1, 1, 0, 0, 0, 0, 0, 0, 1));              // new external code wins
    stage(tick_of(5, 0, 0, 0, 0, 0, 0, 0, 0, 1));              // loop open overwrites it
    stage(tick_of(5, 0, 1, 100, 50, 30, 30, 0, 0, 0));         // brake with throttle
    stage(tick_of(5, 0, 1, 31, 26, 30, 30, 0, 0, 0));          // one past both limits
    stage(tick_of(5, 0, 1, 30, 100, 40, 40, 0, 0, 1));         // brake at limit is fine
    stage(tick_of(60, 0, 1, 0, 0, 50, 0, 0, 0, 0));            // disagreement starts
    stage(tick_of(60, 0, 1, 0, 0, 50, 0, 0, 0, 0));            // lasted long enough
    stage(tick_of(0, 0, 1, 0, 0, 0, 50, 0, 0, 1));             // still disagreeing
    stage(tick_of(7, 0, 1, 0, 0, 45, 35, 0, 0, 1));            // spread at limit clears
    stage(tick_of(3, 0, 1, 0, 0, 10, 10, 61, 0, 0));           // HV up: TS active
    stage(tick_of(3, 0, 1, 16, 0, 10, 10, 60, 1, 0));          // HV at limit, start
    stage(tick_of(1000, 0, 1, 0, 0, 10, 10, 0, 0, 0));         // buzzer half done
    stage(tick_of(1000, 0, 1, 0, 0, 10, 10, 0, 0, 0));         // buzzer done: drive
    stage(tick_of(3, 0, 1, 0, 0, 10, 10, 200, 0, 0));          // enable rises
    stage(tick_of(3, 0, 1, 0, 0, 10, 10, 200, 1, 0));          // start again: TS
    stage(tick_of(3, 0, 1, 0, 0, 10, 10, 59, 0, 0));           // enable falls, HV low
    stage(tick_of(3, 0, 1, 0, 0, 10, 10, 1023, 0, 0));         // TS again
    stage(tick_of(3, 0, 1, 4095, 0, 10, 10, 1023, 1, 0));      // hard brake, no throttle
    stage(tick_of(500, 0, 0, 0, 0, 10, 10, 1023, 0, 0));       // loop opens mid buzzer
    stage(tick_of(0, 0, 0, 0, 0, 10, 10, 0, 0, 1));            // clear refused
    stage(tick_of(0, 0, 1, 0, 0, 0, 0, 0, 0, 1));              // clear accepted
    stage(tick_of(4, 0, 1, 4095, 127, 0, 0, 0, 0, 0));         // out-of-range throttle
    settle();

    load_limits(16'($urandom_range(0, 4095)), 16'($urandom_range(0, 100)),
                16'($urandom_range(0, 100)), 16'($urandom_range(0, 500)),
                16'($urandom_range(0, 1023)), 16'($urandom_range(0, 400)),
                16'($urandom_range(0, 3000)));
    run_phase(275);
    // every threshold and time at zero
    load_limits(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
    run_phase(275);

    // Swap the pressure: sender gappy, receiver nearly always ready.
    send_gap_pct = 78;
    recv_stall_pct = 8;
    // every register saturated by an all-ones write
    load_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_phase(275);
    // longest times with workable thresholds: both timers reach their top
    load_limits(16'd200, 16'd40, 16'd5, 16'hFFFF, 16'd300, 16'd100, 16'hFFFF);
    run_phase(275);

    // Full throughput on both sides.
    send_gap_pct = 0;
    recv_stall_pct = 0;
    load_limits(16'd30, 16'd25, 16'd10, 16'd100, 16'd60, 16'd15, 16'd2000);
    run_phase(275);
    load_limits(16'($urandom_range(0, 4095)), 16'($urandom_range(0, 100)),
                16'($urandom_range(0, 100)), 16'($urandom_range(0, 500)),
                16'($urandom_range(0, 1023)), 16'($urandom_range(0, 400)),
                16'($urandom_range(0, 3000)));
    run_phase(275);

    if (expected_results.size() != 0)
      report_error($sformatf("%0d results never arrived", expected_results.size()));
    $display("Ran %0d ticks, %0d results checked, over %0d register settings",
             ticks_sent, results_checked, settings_loaded);
    $display("Driving reached %0d times; faults: loop %0d, brake %0d, pedal %0d, ext %0d",
             drive_entries, fault_hits[1], fault_hits[2], fault_hits[3], fault_hits[4]);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Watchdog expired with %0d results outstanding", expected_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
